@@ src/tspc_pkg.sv @@
// Shared types and constants for the tachometer PI speed controller.
package tspc_pkg;

    localparam int SPEED_W = 16;
    localparam int DUTY_W = 15;
    localparam int GAIN_W = 10;
    localparam int STEP_W = 8;
    localparam int ERR_W = 18;
    localparam int INTEG_W = 16;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DVD_W = 21;

    localparam logic [DVD_W-1:0] SPEED_SCALE = 21'd2000000;
    localparam logic [SPEED_W-1:0] SPEED_SAT = 16'hFFFF;
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 16'sd14998;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = -16'sd14998;

    localparam logic [1:0] OP_EDGE_LEFT = 2'd0;
    localparam logic [1:0] OP_EDGE_RIGHT = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEFT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN_LEFT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN_RIGHT = 3'd7;

    typedef struct packed {
        logic start;
        logic [SPEED_W-1:0] target;
        logic [SPEED_W-1:0] speed;
        logic signed [INTEG_W-1:0] integ;
        logic signed [ERR_W-1:0] prev;
        logic [DUTY_W-1:0] dmin;
        logic [DUTY_W-1:0] dmax;
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [STEP_W-1:0] dt;
    } pi_in_t;

    typedef struct packed {
        logic done;
        logic [DUTY_W-1:0] duty;
        logic signed [INTEG_W-1:0] integ;
        logic signed [ERR_W-1:0] prev;
    } pi_out_t;

endpackage

@@ src/tach_pi_speed_controller_core.sv @@
// Top level of the two-wheel tachometer and PI speed controller.
// An encoder edge request runs the 21-step serial divider.
// A tick request runs two PI steps, left wheel then right, on one shared multiplier.
// Requests are taken one at a time; a result waits in the output register meanwhile.
// Reset is asynchronous and active low and restores the config, control and wheel state registers, not data regs.
module tach_pi_speed_controller_core #(
    parameter int TIMER_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_wr_en,
    input  logic [tspc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tspc_pkg::CFG_W-1:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic [1:0] opcode,
    input  logic [15:0] capture_time,
    output logic out_valid,
    input  logic out_stall,
    output logic [tspc_pkg::DUTY_W-1:0] left_duty,
    output logic [tspc_pkg::DUTY_W-1:0] right_duty,
    output logic [tspc_pkg::SPEED_W-1:0] left_speed,
    output logic [tspc_pkg::SPEED_W-1:0] right_speed
);
    import tspc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV = 3'd1;
    localparam logic [2:0] S_PIL = 3'd2;
    localparam logic [2:0] S_PIR = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;

    logic [GAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0] integ_gain_reg;
    logic [STEP_W-1:0] step_time_reg;
    logic [SPEED_W-1:0] target_left_reg;
    logic [SPEED_W-1:0] target_right_reg;
    logic [DUTY_W-1:0] duty_max_reg;
    logic [DUTY_W-1:0] duty_min_left_reg;
    logic [DUTY_W-1:0] duty_min_right_reg;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic div_start_reg;
    logic pi_start_reg;
    logic sel_right_reg;
    logic out_valid_reg;
    logic [TIMER_BITS-1:0] period_reg;
    logic [TIMER_BITS-1:0] last_left_reg;
    logic [TIMER_BITS-1:0] last_right_reg;
    logic [SPEED_W-1:0] speed_left_reg;
    logic [SPEED_W-1:0] speed_right_reg;
    logic signed [INTEG_W-1:0] integ_left_reg;
    logic signed [INTEG_W-1:0] integ_right_reg;
    logic signed [ERR_W-1:0] prev_left_reg;
    logic signed [ERR_W-1:0] prev_right_reg;
    logic [DUTY_W-1:0] duty_left_reg;
    logic [DUTY_W-1:0] duty_right_reg;
    logic [DUTY_W-1:0] out_left_duty_reg;
    logic [DUTY_W-1:0] out_right_duty_reg;
    logic [SPEED_W-1:0] out_left_speed_reg;
    logic [SPEED_W-1:0] out_right_speed_reg;

    logic accept;
    logic out_free;
    logic [TIMER_BITS+15:0] cap_wide;
    logic [TIMER_BITS-1:0] cap_now;
    logic div_done;
    logic [SPEED_W-1:0] div_quotient;
    pi_in_t pi_req;
    pi_out_t pi_rsp;

    assign accept = in_valid && !in_stall;
    assign in_stall = state_reg != S_IDLE;
    assign out_free = !out_valid_reg || !out_stall;
    assign cap_wide = {TIMER_BITS'(0), capture_time};
    assign cap_now = cap_wide[TIMER_BITS-1:0];

    tspc_div #(
        .TIMER_BITS(TIMER_BITS)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start_reg),
        .divisor(period_reg),
        .done(div_done),
        .quotient(div_quotient)
    );

    always_comb
    begin
        pi_req.start = pi_start_reg;
        pi_req.dmax = duty_max_reg;
        pi_req.kp = prop_gain_reg;
        pi_req.ki = integ_gain_reg;
        pi_req.dt = step_time_reg;
        if (state_reg == S_PIR)
        begin
            pi_req.target = target_right_reg;
            pi_req.speed = speed_right_reg;
            pi_req.integ = integ_right_reg;
            pi_req.prev = prev_right_reg;
            pi_req.dmin = duty_min_right_reg;
        end
        else
        begin
            pi_req.target = target_left_reg;
            pi_req.speed = speed_left_reg;
            pi_req.integ = integ_left_reg;
            pi_req.prev = prev_left_reg;
            pi_req.dmin = duty_min_left_reg;
        end
    end

    tspc_pi u_pi (
        .clk(clk),
        .rst_n(rst_n),
        .req(pi_req),
        .rsp(pi_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode) inside
                        OP_EDGE_LEFT, OP_EDGE_RIGHT: state_next = S_DIV;
                        OP_TICK: state_next = S_PIL;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_PIL:
            begin
                if (pi_rsp.done)
                begin
                    state_next = S_PIR;
                end
            end
            S_PIR:
            begin
                if (pi_rsp.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg <= '0;
            integ_gain_reg <= '0;
            step_time_reg <= 8'd1;
            target_left_reg <= 16'd150;
            target_right_reg <= 16'd120;
            duty_max_reg <= 15'd14998;
            duty_min_left_reg <= 15'd1500;
            duty_min_right_reg <= 15'd3500;
            state_reg <= S_IDLE;
            div_start_reg <= 1'b0;
            pi_start_reg <= 1'b0;
            sel_right_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            last_left_reg <= '0;
            last_right_reg <= '0;
            speed_left_reg <= '0;
            speed_right_reg <= '0;
            integ_left_reg <= '0;
            integ_right_reg <= '0;
            prev_left_reg <= '0;
            prev_right_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            div_start_reg <= 1'b0;
            pi_start_reg <= 1'b0;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_PROP_GAIN: prop_gain_reg <= cfg_data[GAIN_W-1:0];
                    REG_INTEG_GAIN: integ_gain_reg <= cfg_data[GAIN_W-1:0];
                    REG_STEP_TIME: step_time_reg <= cfg_data[STEP_W-1:0];
                    REG_TARGET_LEFT: target_left_reg <= cfg_data[SPEED_W-1:0];
                    REG_TARGET_RIGHT: target_right_reg <= cfg_data[SPEED_W-1:0];
                    REG_DUTY_MAX: duty_max_reg <= cfg_data[DUTY_W-1:0];
                    REG_DUTY_MIN_LEFT: duty_min_left_reg <= cfg_data[DUTY_W-1:0];
                    REG_DUTY_MIN_RIGHT: duty_min_right_reg <= cfg_data[DUTY_W-1:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (state_reg == S_IDLE && accept)
            begin
                if (opcode == OP_EDGE_LEFT)
                begin
                    last_left_reg <= cap_now;
                    sel_right_reg <= 1'b0;
                    div_start_reg <= 1'b1;
                end
                else if (opcode == OP_EDGE_RIGHT)
                begin
                    last_right_reg <= cap_now;
                    sel_right_reg <= 1'b1;
                    div_start_reg <= 1'b1;
                end
                else if (opcode == OP_TICK)
                begin
                    pi_start_reg <= 1'b1;
                end
            end

            if (state_reg == S_DIV && div_done)
            begin
                if (sel_right_reg)
                begin
                    speed_right_reg <= div_quotient;
                end
                else
                begin
                    speed_left_reg <= div_quotient;
                end
            end

            if (state_reg == S_PIL && pi_rsp.done)
            begin
                integ_left_reg <= pi_rsp.integ;
                prev_left_reg <= pi_rsp.prev;
                pi_start_reg <= 1'b1;
            end

            if (state_reg == S_PIR && pi_rsp.done)
            begin
                integ_right_reg <= pi_rsp.integ;
                prev_right_reg <= pi_rsp.prev;
            end

            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept)
        begin
            if (opcode == OP_EDGE_LEFT)
            begin
                period_reg <= cap_now - last_left_reg;
            end
            else
            begin
                period_reg <= cap_now - last_right_reg;
            end
        end
        if (state_reg == S_PIL && pi_rsp.done)
        begin
            duty_left_reg <= pi_rsp.duty;
        end
        if (state_reg == S_PIR && pi_rsp.done)
        begin
            duty_right_reg <= pi_rsp.duty;
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_left_duty_reg <= duty_left_reg;
            out_right_duty_reg <= duty_right_reg;
            out_left_speed_reg <= speed_left_reg;
            out_right_speed_reg <= speed_right_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign left_duty = out_left_duty_reg;
    assign right_duty = out_right_duty_reg;
    assign left_speed = out_left_speed_reg;
    assign right_speed = out_right_speed_reg;

    a_result_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("Result appeared outside the output state.");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("Divider finished while the sequencer was not waiting for it.");

    a_pi_done_in_pi: assert property (@(posedge clk) disable iff (!rst_n)
        pi_rsp.done |-> (state_reg == S_PIL || state_reg == S_PIR))
        else $error("PI unit finished while the sequencer was not waiting for it.");

    a_edge_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OP_EDGE_LEFT || opcode == OP_EDGE_RIGHT))
            |=> (state_reg == S_DIV && div_start_reg))
        else $error("Encoder edge request did not start the divider.");

endmodule

@@ src/tspc_div.sv @@
// Iterative restoring divider that turns an encoder period into a saturated speed.
module tspc_div #(
    parameter int TIMER_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [TIMER_BITS-1:0] divisor,
    output logic done,
    output logic [tspc_pkg::SPEED_W-1:0] quotient
);
    import tspc_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

    logic busy_reg;
    logic done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [TIMER_BITS-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [TIMER_BITS:0] trial;
    logic [TIMER_BITS:0] diff;
    logic fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff = trial - {1'b0, divisor};
    assign fits = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= SPEED_SCALE;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[TIMER_BITS-1:0] : trial[TIMER_BITS-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quotient = (|quo_reg[DVD_W-1:SPEED_W]) ? SPEED_SAT : quo_reg[SPEED_W-1:0];

endmodule

@@ src/tspc_pi.sv @@
// Sequenced PI step for one wheel built around a single shared multiplier.
module tspc_pi (
    input  logic clk,
    input  logic rst_n,
    input  tspc_pkg::pi_in_t req,
    output tspc_pkg::pi_out_t rsp
);
    import tspc_pkg::*;

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_SUM = 3'd1;
    localparam logic [2:0] P_INT = 3'd2;
    localparam logic [2:0] P_KP = 3'd3;
    localparam logic [2:0] P_KI = 3'd4;
    localparam logic [2:0] P_U = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic done_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [INTEG_W-1:0] acc_reg;
    logic signed [29:0] prod_reg;
    logic signed [29:0] u_reg;
    logic [DUTY_W-1:0] duty_reg;

    logic signed [10:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [29:0] mul_p;
    logic signed [ERR_W-1:0] err_new;
    logic signed [29:0] rnd;
    logic signed [29:0] half;
    logic signed [30:0] acc_sum;
    logic signed [INTEG_W-1:0] acc_clamp;
    logic signed [30:0] u_sum;
    logic signed [30:0] dmax_s;
    logic signed [30:0] dmin_s;
    logic [DUTY_W-1:0] duty_new;

    assign err_new = $signed({2'b00, req.target}) - $signed({2'b00, req.speed});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            P_SUM:
            begin
                mul_a = $signed({3'b000, req.dt});
                mul_b = $signed({err_reg[ERR_W-1], err_reg}) +
                        $signed({req.prev[ERR_W-1], req.prev});
            end
            P_KP:
            begin
                mul_a = $signed({1'b0, req.kp});
                mul_b = $signed({err_reg[ERR_W-1], err_reg});
            end
            P_KI:
            begin
                mul_a = $signed({1'b0, req.ki});
                mul_b = $signed({{3{acc_reg[INTEG_W-1]}}, acc_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign rnd = prod_reg + $signed({29'b0, prod_reg[29]});
    assign half = rnd >>> 1;
    assign acc_sum = $signed({{15{req.integ[INTEG_W-1]}}, req.integ}) +
                     $signed({half[29], half});

    always_comb
    begin
        if (acc_sum > 31'(INTEG_MAX))
        begin
            acc_clamp = INTEG_MAX;
        end
        else if (acc_sum < 31'(INTEG_MIN))
        begin
            acc_clamp = INTEG_MIN;
        end
        else
        begin
            acc_clamp = acc_sum[INTEG_W-1:0];
        end
    end

    assign u_sum = $signed({u_reg[29], u_reg}) + $signed({prod_reg[29], prod_reg});
    assign dmax_s = $signed({16'b0, req.dmax});
    assign dmin_s = $signed({16'b0, req.dmin});

    always_comb
    begin
        if (u_sum >= dmax_s)
        begin
            duty_new = req.dmax;
        end
        else if (u_sum <= dmin_s)
        begin
            duty_new = req.dmin;
        end
        else
        begin
            duty_new = u_sum[DUTY_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            P_IDLE:
            begin
                if (req.start)
                begin
                    state_next = P_SUM;
                end
            end
            P_SUM: state_next = P_INT;
            P_INT: state_next = P_KP;
            P_KP: state_next = P_KI;
            P_KI: state_next = P_U;
            P_U: state_next = P_IDLE;
            default: state_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= state_reg == P_U;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == P_IDLE && req.start)
        begin
            err_reg <= err_new;
        end
        if (state_reg == P_SUM || state_reg == P_KP || state_reg == P_KI)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == P_INT)
        begin
            acc_reg <= acc_clamp;
        end
        if (state_reg == P_KI)
        begin
            u_reg <= prod_reg;
        end
        if (state_reg == P_U)
        begin
            duty_reg <= duty_new;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.duty = duty_reg;
    assign rsp.integ = acc_reg;
    assign rsp.prev = err_reg;

endmodule
